FILE: rtl/pitm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_pkg
// Shared types and constants of the point-in-tetrahedron mesh test unit.
// ----------------------------------------------------------------------------
package pitm_pkg;

  localparam int unsigned MaxTetraDefault  = 1024;
  localparam int unsigned CoordBitsDefault = 20;
  localparam int unsigned CountW           = 11;
  localparam int unsigned SlotW            = 10;
  localparam int unsigned CornerW          = 2;
  localparam int unsigned HitW             = 10;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FACE,
    ST_NEXT,
    ST_DONE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic       clr_faces;  // start a new tetrahedron
    logic       rd_en;      // read one corner
    logic [1:0] rd_corner;
    logic       face_go;    // evaluate one face
    logic [1:0] face_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic face_done;  // current face result registered
    logic tet_in;     // all four faces passed
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/pitm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_in_if / pitm_out_if
// Valid/ready channels for query items and results.
// ----------------------------------------------------------------------------
interface pitm_in_if #(
  parameter int unsigned COORD_BITS = pitm_pkg::CoordBitsDefault
);
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [pitm_pkg::SlotW-1:0]        tetra_slot;
  logic [pitm_pkg::CornerW-1:0]      corner;
  logic signed [COORD_BITS-1:0]      coord_x;
  logic signed [COORD_BITS-1:0]      coord_y;
  logic signed [COORD_BITS-1:0]      coord_z;
  modport source (output valid, func, tetra_slot, corner, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, func, tetra_slot, corner, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface pitm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      inside_res;
  logic [pitm_pkg::HitW-1:0] hit_index;
  modport source (output valid, inside_res, hit_index, input ready);
  modport sink   (input valid, inside_res, hit_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/pitm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pitm_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/pitm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_datapath
// Corner loader and per-face same-side test. One face takes a fixed
// sequence of registered steps: edges, six cross products, normal,
// dot-term partial products, partial combine, dot sums, sign compare.
// ----------------------------------------------------------------------------
module pitm_datapath #(
  parameter int unsigned COORD_BITS = pitm_pkg::CoordBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         pt_ld_i,
  input  wire logic [3*COORD_BITS-1:0]      pt_i,
  input  wire logic [3*COORD_BITS-1:0]      rd_data_i,
  input  wire pitm_pkg::dp_cmd_t            cmd_i,
  output pitm_pkg::dp_sts_t                 sts_o
);
  localparam int unsigned DW = COORD_BITS + 1;      // difference
  localparam int unsigned PW = 2 * DW;              // one product
  localparam int unsigned NW = PW + 1;              // normal component
  localparam int unsigned QW = NW + DW;             // dot term
  localparam int unsigned SW = QW + 2;              // dot sum

  logic signed [COORD_BITS-1:0] vx_q [4];
  logic signed [COORD_BITS-1:0] vy_q [4];
  logic signed [COORD_BITS-1:0] vz_q [4];
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic [1:0] ld_corner_q;
  logic       ld_pend_q;

  // point register
  always_ff @(posedge clk_i) begin
    if (pt_ld_i) begin
      px_q <= pt_i[COORD_BITS-1:0];
      py_q <= pt_i[2*COORD_BITS-1:COORD_BITS];
      pz_q <= pt_i[3*COORD_BITS-1:2*COORD_BITS];
    end
  end

  // corner capture from the registered RAM read data, tracked by ld_pend_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_pend_q <= 1'b0;
    end else begin
      ld_pend_q <= cmd_i.rd_en;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) ld_corner_q <= cmd_i.rd_corner;
    if (ld_pend_q) begin
      vx_q[ld_corner_q] <= rd_data_i[COORD_BITS-1:0];
      vy_q[ld_corner_q] <= rd_data_i[2*COORD_BITS-1:COORD_BITS];
      vz_q[ld_corner_q] <= rd_data_i[3*COORD_BITS-1:2*COORD_BITS];
    end
  end

  // face corner selection: v0..v2 and opposite corner
  logic [1:0] i0, i1, i2, i3;
  always_comb begin
    i0 = cmd_i.face_sel;
    i1 = cmd_i.face_sel + 2'd1;
    i2 = cmd_i.face_sel + 2'd2;
    i3 = cmd_i.face_sel + 2'd3;
  end

  // step 1: edge and offset differences
  logic signed [DW-1:0] e1_q [3], e2_q [3], eo_q [3], ep_q [3];
  logic [5:0] stg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= {stg_q[4:0], cmd_i.face_go};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.face_go) begin
      e1_q[0] <= DW'(vx_q[i1]) - DW'(vx_q[i0]);
      e1_q[1] <= DW'(vy_q[i1]) - DW'(vy_q[i0]);
      e1_q[2] <= DW'(vz_q[i1]) - DW'(vz_q[i0]);
      e2_q[0] <= DW'(vx_q[i2]) - DW'(vx_q[i0]);
      e2_q[1] <= DW'(vy_q[i2]) - DW'(vy_q[i0]);
      e2_q[2] <= DW'(vz_q[i2]) - DW'(vz_q[i0]);
      eo_q[0] <= DW'(vx_q[i3]) - DW'(vx_q[i0]);
      eo_q[1] <= DW'(vy_q[i3]) - DW'(vy_q[i0]);
      eo_q[2] <= DW'(vz_q[i3]) - DW'(vz_q[i0]);
      ep_q[0] <= DW'(px_q) - DW'(vx_q[i0]);
      ep_q[1] <= DW'(py_q) - DW'(vy_q[i0]);
      ep_q[2] <= DW'(pz_q) - DW'(vz_q[i0]);
    end
  end

  // step 2: six cross products (one multiplier each, registered)
  logic signed [PW-1:0] cp_q [6];
  always_ff @(posedge clk_i) begin
    if (stg_q[0]) begin
      cp_q[0] <= e1_q[1] * e2_q[2];
      cp_q[1] <= e1_q[2] * e2_q[1];
      cp_q[2] <= e1_q[2] * e2_q[0];
      cp_q[3] <= e1_q[0] * e2_q[2];
      cp_q[4] <= e1_q[0] * e2_q[1];
      cp_q[5] <= e1_q[1] * e2_q[0];
    end
  end

  // step 3: normal
  logic signed [NW-1:0] n_q [3];
  always_ff @(posedge clk_i) begin
    if (stg_q[1]) begin
      n_q[0] <= NW'(cp_q[0]) - NW'(cp_q[1]);
      n_q[1] <= NW'(cp_q[2]) - NW'(cp_q[3]);
      n_q[2] <= NW'(cp_q[4]) - NW'(cp_q[5]);
    end
  end

  // step 4: dot terms; products split into two partial products per term
  localparam int unsigned LW = (NW + 1) / 2;
  logic signed [QW-1:0] plo_q [6], phi_q [6];
  always_ff @(posedge clk_i) begin
    if (stg_q[2]) begin
      for (int k = 0; k < 3; k++) begin
        plo_q[k]   <= QW'($signed({1'b0, n_q[k][LW-1:0]}) * eo_q[k]);
        phi_q[k]   <= QW'($signed(n_q[k][NW-1:LW]) * eo_q[k]);
        plo_q[k+3] <= QW'($signed({1'b0, n_q[k][LW-1:0]}) * ep_q[k]);
        phi_q[k+3] <= QW'($signed(n_q[k][NW-1:LW]) * ep_q[k]);
      end
    end
  end

  // step 5: combine partials
  logic signed [QW-1:0] t_q [6];
  always_ff @(posedge clk_i) begin
    if (stg_q[3]) begin
      for (int k = 0; k < 6; k++) begin
        t_q[k] <= (phi_q[k] <<< LW) + plo_q[k];
      end
    end
  end

  // step 6: dot sums
  logic signed [SW-1:0] dd_q, dp_q;
  always_ff @(posedge clk_i) begin
    if (stg_q[4]) begin
      dd_q <= SW'(t_q[0]) + SW'(t_q[1]) + SW'(t_q[2]);
      dp_q <= SW'(t_q[3]) + SW'(t_q[4]) + SW'(t_q[5]);
    end
  end

  // step 7: sign compare, accumulate over faces
  logic face_ok, all_ok_q;
  assign face_ok = (dd_q != '0) && (dp_q != '0) && (dd_q[SW-1] == dp_q[SW-1]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_ok_q <= 1'b0;
    end else if (cmd_i.clr_faces) begin
      all_ok_q <= 1'b1;
    end else if (stg_q[5]) begin
      all_ok_q <= all_ok_q & face_ok;
    end
  end

  always_comb begin
    sts_o.face_done = stg_q[5];
    sts_o.tet_in    = all_ok_q & (~stg_q[5] | face_ok);
  end
endmodule
`default_nettype wire

FILE: rtl/pitm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pitm_ctrl
// Sequencer: gives input ready while idle, walks the table for a query, one face
// at a time, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module pitm_ctrl #(
  parameter int unsigned MAX_TETRA = pitm_pkg::MaxTetraDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [pitm_pkg::CountW-1:0]  tetra_count_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_func_i,
  output logic                              in_ready_o,
  output logic                              pt_ld_o,
  output logic [$clog2(MAX_TETRA*4)-1:0]    rd_addr_o,
  output pitm_pkg::dp_cmd_t                 cmd_o,
  input  wire pitm_pkg::dp_sts_t            sts_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              out_inside_o,
  output logic [pitm_pkg::HitW-1:0]         out_hit_o
);
  localparam int unsigned TW = (MAX_TETRA > 1) ? $clog2(MAX_TETRA) : 1;
  localparam int unsigned CW = $clog2(MAX_TETRA + 1);
  localparam int unsigned AW = $clog2(MAX_TETRA * 4);

  pitm_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d, lim_q, lim_d;
  logic [2:0]    cnt_q, cnt_d;        // corner or face step
  logic          busy_q, busy_d;      // face in flight
  logic          ov_q, ov_d, in_q, in_d;
  logic [pitm_pkg::HitW-1:0] hit_q, hit_d;
  logic [CW-1:0] cnt_sat;

  always_comb begin
    if (32'(tetra_count_i) > 32'(MAX_TETRA)) cnt_sat = CW'(MAX_TETRA);
    else cnt_sat = CW'(tetra_count_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pitm_pkg::ST_IDLE: begin
        if (in_valid_i && in_func_i == pitm_pkg::FuncQuery && !ov_q) begin
          state_d = (cnt_sat == '0) ? pitm_pkg::ST_DONE : pitm_pkg::ST_FETCH;
        end
      end
      pitm_pkg::ST_FETCH: if (cnt_q == 3'd5) state_d = pitm_pkg::ST_FACE;
      pitm_pkg::ST_FACE: begin
        if (sts_i.face_done && (!sts_i.tet_in || cnt_q == 3'd3)) state_d = pitm_pkg::ST_NEXT;
      end
      pitm_pkg::ST_NEXT: begin
        if (in_q || idx_q + CW'(1) == lim_q) state_d = pitm_pkg::ST_DONE;
        else state_d = pitm_pkg::ST_FETCH;
      end
      pitm_pkg::ST_DONE: state_d = pitm_pkg::ST_IDLE;
      default: state_d = pitm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath registers
  always_comb begin
    idx_d = idx_q; lim_d = lim_q; cnt_d = cnt_q; busy_d = busy_q;
    ov_d = ov_q; in_d = in_q; hit_d = hit_q;
    cmd_o = '0;
    pt_ld_o = 1'b0;
    in_ready_o = (state_q == pitm_pkg::ST_IDLE) && !ov_q;
    rd_addr_o = AW'({idx_q[TW-1:0], cnt_q[1:0]});
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      pitm_pkg::ST_IDLE: begin
        if (in_valid_i && in_func_i == pitm_pkg::FuncQuery && !ov_q) begin
          pt_ld_o = 1'b1; idx_d = '0; lim_d = cnt_sat; cnt_d = '0;
          in_d = 1'b0; hit_d = '0;
        end
      end
      pitm_pkg::ST_FETCH: begin
        cmd_o.rd_en = (cnt_q < 3'd4);
        cmd_o.rd_corner = cnt_q[1:0];
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          cnt_d = '0; cmd_o.clr_faces = 1'b1; busy_d = 1'b0;
        end
      end
      pitm_pkg::ST_FACE: begin
        cmd_o.face_sel = cnt_q[1:0];
        if (!busy_q) begin
          cmd_o.face_go = 1'b1; busy_d = 1'b1;
        end else if (sts_i.face_done) begin
          busy_d = 1'b0;
          cnt_d = cnt_q + 3'd1;
          if (sts_i.tet_in && cnt_q == 3'd3) begin
            in_d = 1'b1; hit_d = pitm_pkg::HitW'(idx_q);
          end
        end
      end
      pitm_pkg::ST_NEXT: begin
        idx_d = idx_q + CW'(1); cnt_d = '0;
      end
      pitm_pkg::ST_DONE: ov_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pitm_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end
  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
    in_q  <= in_d;
    hit_q <= hit_d;
  end

  assign out_valid_o  = ov_q;
  assign out_inside_o = in_q;
  assign out_hit_o    = hit_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pitm_pkg::ST_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_done_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pitm_pkg::ST_DONE) |=> out_valid_o) else $error("result lost");
  a_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_inside_o) |-> (out_hit_o == '0)) else $error("stray index");
`endif
endmodule
`default_nettype wire

FILE: rtl/point_in_tetra_mesh_test_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_tetra_mesh_test_unit
// Exact same-side point-in-tetrahedron search over a stored mesh.
// ----------------------------------------------------------------------------
// A corner write (func 0) stores one corner and gives no result.
// A query (func 1) walks entries 0..tetra_count-1 (saturated at MAX_TETRA);
// each entry reads its four corners from the corner RAM's single read port,
// then runs its faces through a 7-step registered face pipeline, a face at a
// time, and then advances, stopping early on a failed face or on the first
// hit. The corner store is not cleared: query only fully written entries.
module point_in_tetra_mesh_test_unit #(
  parameter int unsigned MAX_TETRA  = pitm_pkg::MaxTetraDefault,
  parameter int unsigned COORD_BITS = pitm_pkg::CoordBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pitm_pkg::CountW-1:0] cfg_wdata_i,
  pitm_in_if.sink                          in_if,
  pitm_out_if.source                       out_if
);
  localparam int unsigned AW = $clog2(MAX_TETRA * 4);

  logic [pitm_pkg::CountW-1:0] tetra_count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tetra_count_q <= '0;
    else if (cfg_we_i) tetra_count_q <= cfg_wdata_i;
  end

  logic ready, pt_ld, we;
  logic [AW-1:0] raddr, waddr;
  logic [3*COORD_BITS-1:0] rdata, wdata;
  pitm_pkg::dp_cmd_t cmd;
  pitm_pkg::dp_sts_t sts;

  assign in_if.ready = ready;
  assign wdata = {in_if.coord_z, in_if.coord_y, in_if.coord_x};
  assign waddr = AW'({in_if.tetra_slot, in_if.corner});
  assign we = in_if.valid && ready && in_if.func == pitm_pkg::FuncWrite &&
              32'(in_if.tetra_slot) < 32'(MAX_TETRA);

  pitm_ram #(.WIDTH(3*COORD_BITS), .DEPTH(MAX_TETRA*4)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd.rd_en), .raddr_i(raddr), .rdata_o(rdata)
  );

  pitm_ctrl #(.MAX_TETRA(MAX_TETRA)) u_ctrl (
    .clk_i, .rst_ni, .tetra_count_i(tetra_count_q),
    .in_valid_i(in_if.valid), .in_func_i(in_if.func), .in_ready_o(ready),
    .pt_ld_o(pt_ld), .rd_addr_o(raddr), .cmd_o(cmd), .sts_i(sts),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_inside_o(out_if.inside_res), .out_hit_o(out_if.hit_index)
  );

  pitm_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk_i, .rst_ni, .pt_ld_i(pt_ld), .pt_i(wdata), .rd_data_i(rdata),
    .cmd_i(cmd), .sts_o(sts)
  );

`ifndef SYNTH
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(tetra_count_q)) else $error("count changed");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ready) else $error("write while busy");
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !cmd.face_go) else $error("read during face");
`endif
endmodule
`default_nettype wire

FILE: verif/tb_pitm_if_note.sv
// ----------------------------------------------------------------------------
// pitm testbench channel types
// Item and result records shared by the stimulus and the scoreboard.
// ----------------------------------------------------------------------------
package tb_pitm_types_pkg;

  typedef struct {
    logic                       func;
    logic [pitm_pkg::SlotW-1:0] tetra_slot;
    logic [1:0]                 corner;
    logic signed [19:0]         coord_x;
    logic signed [19:0]         coord_y;
    logic signed [19:0]         coord_z;
  } mesh_item_t;

  typedef struct {
    logic                      inside_res;
    logic [pitm_pkg::HitW-1:0] hit_index;
  } hit_t;

endpackage

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Tests the point-in-tetrahedron mesh search: corner writes and point queries
// go in through a bursty valid/ready source, results come back through a
// stalling sink and are checked against an exact integer same-side predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumTetra   = 1024;
  localparam int          FillTetra  = 48;
  localparam longint      CycleLimit = 4000000;
  localparam int          DrainWait  = 60;

  typedef logic signed [127:0] wide_t;
  typedef int vec3_t[3];

  // Predicts the search result of each query, holds expected results in order.
  class tetra_hit_board;
    int          cx[NumTetra*4];
    int          cy[NumTetra*4];
    int          cz[NumTetra*4];
    int unsigned search_len;
    tb_pitm_types_pkg::hit_t hits_due[$];
    int          errors;

    function bit face_pass(vec3_t p, vec3_t v0, vec3_t v1, vec3_t v2, vec3_t opp);
      wide_t e1[3], e2[3], n[3], dd, dp;
      dd = 0;
      dp = 0;
      for (int k = 0; k < 3; k++) begin
        e1[k] = wide_t'(v1[k]) - wide_t'(v0[k]);
        e2[k] = wide_t'(v2[k]) - wide_t'(v0[k]);
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      for (int k = 0; k < 3; k++) begin
        dd += n[k] * (wide_t'(opp[k]) - wide_t'(v0[k]));
        dp += n[k] * (wide_t'(p[k]) - wide_t'(v0[k]));
      end
      return (dd != 0) && (dp != 0) && ((dd < 0) == (dp < 0));
    endfunction

    function bit tetra_holds(vec3_t p, int t);
      vec3_t v[4];
      for (int i = 0; i < 4; i++) begin
        v[i][0] = cx[t*4+i];
        v[i][1] = cy[t*4+i];
        v[i][2] = cz[t*4+i];
      end
      return face_pass(p, v[0], v[1], v[2], v[3]) && face_pass(p, v[1], v[2], v[3], v[0]) &&
             face_pass(p, v[2], v[3], v[0], v[1]) && face_pass(p, v[3], v[0], v[1], v[2]);
    endfunction

    function void note_input(tb_pitm_types_pkg::mesh_item_t it);
      vec3_t p;
      tb_pitm_types_pkg::hit_t h;
      int    a, lim;
      if (it.func == pitm_pkg::FuncWrite) begin
        a = int'(it.tetra_slot) * 4 + int'(it.corner);
        cx[a] = it.coord_x;
        cy[a] = it.coord_y;
        cz[a] = it.coord_z;
        return;
      end
      p[0] = it.coord_x;
      p[1] = it.coord_y;
      p[2] = it.coord_z;
      h.inside_res = 1'b0;
      h.hit_index  = '0;
      lim = (search_len > NumTetra) ? NumTetra : search_len;
      for (int t = 0; t < lim; t++) begin
        if (tetra_holds(p, t)) begin
          h.inside_res = 1'b1;
          h.hit_index  = t[pitm_pkg::HitW-1:0];
          break;
        end
      end
      hits_due = {hits_due, h};
    endfunction

    function void check_result(logic ins, logic [pitm_pkg::HitW-1:0] idx);
      tb_pitm_types_pkg::hit_t h;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result inside=%0b index=%0d", $time, ins, idx);
        errors++;
        return;
      end
      h = hits_due.pop_front();
      if (ins !== h.inside_res) begin
        $display("%0t: inside_res expected %0b actual %0b", $time, h.inside_res, ins);
        errors++;
      end
      if (idx !== h.hit_index) begin
        $display("%0t: hit_index expected %0d actual %0d", $time, h.hit_index, idx);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [pitm_pkg::CountW-1:0] cfg_wdata_i;

  pitm_in_if #(.COORD_BITS(20)) in_ch();
  pitm_out_if out_ch();

  point_in_tetra_mesh_test_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  tetra_hit_board board = new();
  int  burst_left;
  longint cycles;

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result sink: random stall pattern, chosen anew each time sink_cnt wraps
  int sink_mode;
  int sink_cnt;
  always @(negedge clk_i) begin
    if (sink_cnt == 0) sink_mode = $urandom_range(2);
    sink_cnt = (sink_cnt + 1) % 64;
    case (sink_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(1) == 1);
      default: out_ch.ready = ($urandom_range(4) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.inside_res, out_ch.hit_index);
  end

  // one transfer on the input channel; called at a falling edge
  task automatic push_item(tb_pitm_types_pkg::mesh_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(16, 1);
    end
    in_ch.valid      = 1'b1;
    in_ch.func       = it.func;
    in_ch.tetra_slot = it.tetra_slot;
    in_ch.corner     = it.corner;
    in_ch.coord_x    = it.coord_x;
    in_ch.coord_y    = it.coord_y;
    in_ch.coord_z    = it.coord_z;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    board.note_input(it);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic write_corner(int slot, int c, int x, int y, int z);
    tb_pitm_types_pkg::mesh_item_t it;
    it.func       = pitm_pkg::FuncWrite;
    it.tetra_slot = slot[pitm_pkg::SlotW-1:0];
    it.corner     = c[1:0];
    it.coord_x    = x[19:0];
    it.coord_y    = y[19:0];
    it.coord_z    = z[19:0];
    push_item(it);
  endtask

  task automatic query_point(int x, int y, int z);
    tb_pitm_types_pkg::mesh_item_t it;
    it.func       = pitm_pkg::FuncQuery;
    it.tetra_slot = 10'($urandom);
    it.corner     = 2'($urandom);
    it.coord_x    = x[19:0];
    it.coord_y    = y[19:0];
    it.coord_z    = z[19:0];
    push_item(it);
  endtask

  // wait for all results, let the block settle, then write the count
  task automatic set_count(int unsigned v);
    in_ch.valid = 1'b0;
    while (board.hits_due.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v[pitm_pkg::CountW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.search_len = v;
  endtask

  function automatic int rnd_coord();
    return int'($signed(20'($urandom)));
  endfunction

  // random tetrahedron: mostly compact shapes, some spanning the full range
  task automatic write_rand_tetra(int slot);
    int bx, by, bz, span;
    if ($urandom_range(4) == 0) begin
      for (int c = 0; c < 4; c++) write_corner(slot, c, rnd_coord(), rnd_coord(), rnd_coord());
      return;
    end
    case ($urandom_range(2))
      0: span = 16;
      1: span = 2000;
      default: span = 60000;
    endcase
    bx = $urandom_range(800000) - 400000;
    by = $urandom_range(800000) - 400000;
    bz = $urandom_range(800000) - 400000;
    for (int c = 0; c < 4; c++)
      write_corner(slot, c, bx + $urandom_range(2*span) - span,
                   by + $urandom_range(2*span) - span, bz + $urandom_range(2*span) - span);
  endtask

  // centroid of a stored tetrahedron, optionally jittered
  task automatic query_near(int t, int jitter);
    int sx, sy, sz;
    sx = 0;
    sy = 0;
    sz = 0;
    for (int i = 0; i < 4; i++) begin
      sx += board.cx[t*4+i];
      sy += board.cy[t*4+i];
      sz += board.cz[t*4+i];
    end
    query_point(sx / 4 + $urandom_range(2*jitter) - jitter,
                sy / 4 + $urandom_range(2*jitter) - jitter,
                sz / 4 + $urandom_range(2*jitter) - jitter);
  endtask

  initial begin
    int cnt, sel;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.func  = pitm_pkg::FuncWrite;
    in_ch.tetra_slot = '0;
    in_ch.corner  = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready  = 1'b1;
    board.search_len = 0;
    burst_left = 0;
    cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty search, unit tetra, flat tetra, full-range tetra
    query_point(10, 10, 10);
    write_corner(0, 0, 0, 0, 0);
    write_corner(0, 1, 256, 0, 0);
    write_corner(0, 2, 0, 256, 0);
    write_corner(0, 3, 0, 0, 256);
    write_corner(1, 0, 0, 0, 0);
    write_corner(1, 1, 512, 0, 0);
    write_corner(1, 2, 0, 512, 0);
    write_corner(1, 3, 100, 100, 0);
    write_corner(2, 0, -524288, -524288, -524288);
    write_corner(2, 1, 524287, -524288, -524288);
    write_corner(2, 2, -524288, 524287, -524288);
    write_corner(2, 3, -524288, -524288, 524287);
    set_count(3);
    query_point(10, 10, 10);
    query_point(0, 10, 10);
    query_point(50, 50, 0);
    query_point(-400000, -400000, -400000);
    query_point(524287, 524287, 524287);
    query_point(-524288, -524288, -524288);
    query_point(64, 64, 64);

    // fill the low part of the table
    for (int s = 3; s < FillTetra; s++) write_rand_tetra(s);

    // count past capacity and at capacity, where the point hits the first entry, then zero
    set_count(2047);
    query_point(64, 64, 64);
    set_count(1024);
    query_point(64, 64, 64);
    set_count(0);
    query_near(0, 0);

    // random phases over small search lengths
    for (int ph = 0; ph < 10; ph++) begin
      cnt = ($urandom_range(5) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
      set_count(cnt);
      repeat (29) begin
        sel = $urandom_range(99);
        if (sel < 10) write_rand_tetra($urandom_range(cnt + 1));
        else if (sel < 18)
          write_corner($urandom_range(cnt + 1), $urandom_range(3),
                       rnd_coord(), rnd_coord(), rnd_coord());
        else if (sel < 65) query_near($urandom_range(cnt - 1), 0);
        else if (sel < 82) query_near($urandom_range(cnt - 1), 3);
        else query_point(rnd_coord(), rnd_coord(), rnd_coord());
      end
    end

    // drain
    in_ch.valid = 1'b0;
    while (board.hits_due.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pitm_pkg.sv
rtl/pitm_if.sv
rtl/pitm_ram.sv
rtl/pitm_datapath.sv
rtl/pitm_ctrl.sv
rtl/point_in_tetra_mesh_test_unit.sv
verif/tb_pitm_if_note.sv
verif/tb.sv
